// ===== hw/rtl/ogd_pkg.sv =====
// ----------------------------------------------------------------------------
// ogd_pkg
// shared constants and types for the obstacle dilation core
// ----------------------------------------------------------------------------
package ogd_pkg;

    localparam int CFG_W       = 11;
    localparam int VAL_W       = 8;
    localparam int MAX_HEIGHT  = 1024;
    localparam int ROW_W       = 10;
    localparam int CFG_IDX_W   = 2;

    localparam logic signed [VAL_W-1:0] OCC_LIMIT   = 8'sd40;
    localparam logic signed [VAL_W-1:0] GROWN_VALUE = 8'sd100;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_STEPS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_ENABLE = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } t_col_entry;

endpackage

// ===== hw/rtl/ogd_ram.sv =====
// ----------------------------------------------------------------------------
// ogd_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ogd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/occupancy_grid_obstacle_dilation_core.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_dilation_core
// streaming square dilation of an occupancy grid in raster order
// ----------------------------------------------------------------------------
// Map cells enter on the input channel (i_in_valid / o_in_ready) in raster
// order; each word is a cell (kind 0) or a flush (kind 1). Each cell leaves on
// the output channel (o_out_valid / i_out_ready) grow_steps rows plus
// grow_steps cells later, forced to 100 when growth is enabled and a source
// lies within the square of radius grow_steps around it. Flush words push out
// the tail of the map. Registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while idle, which the core does
// not enforce; any write restarts the stream.
// A cell word passes through S_WR and S_COLWR, a releasing flush word goes
// straight to the scan; a word that releases a result scans the window in
// S_SCAN and S_LAST, one read per window column from the column memory (last
// source row per column), then loads the result in S_OUT and returns to S_IDLE.
// The output register holds a result while the receiver stalls; the core
// takes the next word meanwhile and waits only when its next result is ready.
// Reset clears counters, presets registers; memories need no clearing since a
// column entry is renewed by row 0 of every map before it is read.
// ----------------------------------------------------------------------------
module occupancy_grid_obstacle_dilation_core #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_GROW  = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ogd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ogd_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_kind,
    input  logic signed [ogd_pkg::VAL_W-1:0]      i_cell_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ogd_pkg::VAL_W-1:0]      o_out_value,
    output logic                                  o_last_cell
);

    import ogd_pkg::*;

    localparam int RING_DEPTH = (2 * MAX_GROW + 1) * MAX_WIDTH;
    localparam int RA_W       = $clog2(RING_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WD_W       = $clog2(MAX_WIDTH + 1);
    localparam int GW         = $clog2(MAX_GROW + 1);
    localparam int KW         = $clog2(2 * MAX_GROW + 1);
    localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int EW         = $bits(t_col_entry);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WR    = 3'd1;
    localparam logic [2:0] S_COLWR = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]              r_state;
    logic [CFG_W-1:0]        r_map_width;
    logic [CFG_W-1:0]        r_map_height;
    logic [3:0]              r_grow_steps;
    logic                    r_grow_enable;
    logic [CNT_W-1:0]        r_cin;
    logic [CNT_W-1:0]        r_cout;
    logic [COL_W-1:0]        r_in_col;
    logic [ROW_W-1:0]        r_in_row;
    logic [COL_W-1:0]        r_out_col;
    logic [ROW_W-1:0]        r_out_row;
    logic [RA_W-1:0]         r_wptr;
    logic [RA_W-1:0]         r_rptr;
    logic signed [VAL_W-1:0] r_value;
    logic [KW-1:0]           r_k;
    logic                    r_chk;
    logic                    r_hit;
    logic                    r_ov;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_last;

    logic [WD_W-1:0]         w_eff;
    logic [CFG_W-1:0]        h_eff;
    logic [GW-1:0]           g_eff;
    logic [CNT_W-1:0]        total;
    logic [CNT_W-1:0]        delay;
    logic [CNT_W-1:0]        cin_inc;
    logic [CNT_W-1:0]        cout_inc;
    logic                    src;
    t_col_entry              col_q;
    t_col_entry              col_new;
    logic [EW-1:0]           col_rdata;
    logic [COL_W-1:0]        col_raddr;
    logic [COL_W+1:0]        scan_sum;
    logic                    scan_ok;
    logic                    entry_hit;
    logic                    out_load;
    logic signed [VAL_W-1:0] ring_q;

    always_comb begin
        if (r_map_width == '0) begin
            w_eff = WD_W'(1);
        end else if (32'(r_map_width) > MAX_WIDTH) begin
            w_eff = WD_W'(MAX_WIDTH);
        end else begin
            w_eff = WD_W'(r_map_width);
        end
        if (r_map_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (32'(r_map_height) > MAX_HEIGHT) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_map_height;
        end
        if (32'(r_grow_steps) > MAX_GROW) begin
            g_eff = GW'(MAX_GROW);
        end else begin
            g_eff = GW'(r_grow_steps);
        end
    end

    assign total    = CNT_W'(w_eff) * CNT_W'(h_eff);
    assign delay    = CNT_W'(g_eff) * CNT_W'(w_eff) + CNT_W'(g_eff);
    assign cin_inc  = r_cin + CNT_W'(1);
    assign cout_inc = r_cout + CNT_W'(1);

    // source test for the cell being stored
    assign src = (r_value > OCC_LIMIT || r_value < 0)
              && (CFG_W'(r_in_row) >= CFG_W'(g_eff))
              && (CFG_W'(r_in_row) + CFG_W'(g_eff) + CFG_W'(1) <= h_eff)
              && (WD_W'(r_in_col) >= WD_W'(g_eff))
              && (WD_W'(r_in_col) + WD_W'(g_eff) + WD_W'(1) <= w_eff);

    assign col_q = t_col_entry'(col_rdata);

    always_comb begin
        if (src) begin
            col_new.valid = 1'b1;
            col_new.row   = r_in_row;
        end else if (r_in_row == '0) begin
            col_new.valid = 1'b0;
            col_new.row   = '0;
        end else begin
            col_new = col_q;
        end
    end

    // window column for scan step k is out_col + k - g
    assign scan_sum  = (COL_W+2)'(r_out_col) + (COL_W+2)'(r_k);
    assign scan_ok   = (scan_sum >= (COL_W+2)'(g_eff))
                    && (scan_sum - (COL_W+2)'(g_eff) < (COL_W+2)'(w_eff));
    assign col_raddr = (r_state == S_SCAN) ? COL_W'(scan_sum - (COL_W+2)'(g_eff)) : r_in_col;
    assign entry_hit = r_chk && col_q.valid
                    && ((ROW_W+1)'(col_q.row) + (ROW_W+1)'(g_eff) >= (ROW_W+1)'(r_out_row));

    assign out_load   = (r_state == S_OUT) && (!r_ov || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_we;

    ogd_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (VAL_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (r_wptr),
        .i_wdata (r_value),
        .i_raddr (r_rptr),
        .o_rdata (ring_q)
    );

    ogd_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (EW)
    ) u_colmem (
        .i_clk   (i_clk),
        .i_we    (r_state == S_COLWR),
        .i_waddr (r_in_col),
        .i_wdata (col_new),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_map_width   <= CFG_W'(1024);
            r_map_height  <= CFG_W'(1024);
            r_grow_steps  <= '0;
            r_grow_enable <= 1'b0;
            r_cin         <= '0;
            r_cout        <= '0;
            r_in_col      <= '0;
            r_in_row      <= '0;
            r_out_col     <= '0;
            r_out_row     <= '0;
            r_wptr        <= '0;
            r_rptr        <= '0;
            r_k           <= '0;
            r_chk         <= 1'b0;
            r_hit         <= 1'b0;
            r_ov          <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAP_WIDTH:   r_map_width   <= i_cfg_data;
                    CFG_MAP_HEIGHT:  r_map_height  <= i_cfg_data;
                    CFG_GROW_STEPS:  r_grow_steps  <= i_cfg_data[3:0];
                    CFG_GROW_ENABLE: r_grow_enable <= i_cfg_data[0];
                    default: ;
                endcase
                r_cin     <= '0;
                r_cout    <= '0;
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_wptr    <= '0;
                r_rptr    <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_in_valid) begin
                            r_value <= i_cell_value;
                            r_k     <= '0;
                            r_chk   <= 1'b0;
                            r_hit   <= 1'b0;
                            if (r_cin < total) begin
                                if (!i_kind) begin
                                    r_state <= S_WR;
                                end
                            end else if (r_cout < total) begin
                                r_state <= S_SCAN;
                            end
                        end
                    end
                    S_WR: begin
                        r_state <= S_COLWR;
                    end
                    S_COLWR: begin
                        r_cin <= cin_inc;
                        if (WD_W'(r_in_col) + WD_W'(1) == w_eff) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + ROW_W'(1);
                        end else begin
                            r_in_col <= r_in_col + COL_W'(1);
                        end
                        if (32'(r_wptr) == RING_DEPTH - 1) begin
                            r_wptr <= '0;
                        end else begin
                            r_wptr <= r_wptr + RA_W'(1);
                        end
                        r_state <= (cin_inc - r_cout > delay) ? S_SCAN : S_IDLE;
                    end
                    S_SCAN: begin
                        r_chk <= scan_ok;
                        if (entry_hit) begin
                            r_hit <= 1'b1;
                        end
                        if (r_k == KW'({g_eff, 1'b0})) begin
                            r_state <= S_LAST;
                        end
                        r_k <= r_k + KW'(1);
                    end
                    S_LAST: begin
                        if (entry_hit) begin
                            r_hit <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        if (out_load) begin
                            r_state <= S_IDLE;
                            if (cout_inc >= total) begin
                                r_cin     <= '0;
                                r_cout    <= '0;
                                r_in_col  <= '0;
                                r_in_row  <= '0;
                                r_out_col <= '0;
                                r_out_row <= '0;
                                r_wptr    <= '0;
                                r_rptr    <= '0;
                            end else begin
                                r_cout <= cout_inc;
                                if (WD_W'(r_out_col) + WD_W'(1) == w_eff) begin
                                    r_out_col <= '0;
                                    r_out_row <= r_out_row + ROW_W'(1);
                                end else begin
                                    r_out_col <= r_out_col + COL_W'(1);
                                end
                                if (32'(r_rptr) == RING_DEPTH - 1) begin
                                    r_rptr <= '0;
                                end else begin
                                    r_rptr <= r_rptr + RA_W'(1);
                                end
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= (r_hit && r_grow_enable) ? GROWN_VALUE : ring_q;
            r_last      <= (cout_inc == total);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_value = r_out_value;
    assign o_last_cell = r_last;

endmodule

// ===== verif/occupancy_grid_obstacle_dilation_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_dilation_core_test
// self-checking testbench for the streaming obstacle dilation core
// ----------------------------------------------------------------------------
// Maps are streamed in raster order, followed by flush words that push out the
// delayed tail. A behavioral dilation model, fed at each accepted input word,
// builds the expected output words; the monitor checks every output word
// against them in order. Register settings change between maps while the core
// is idle, with random sender gaps and receiver stalls in several phases.
// ----------------------------------------------------------------------------
module occupancy_grid_obstacle_dilation_core_test;
    import ogd_pkg::*;

    localparam int GRID_MAX_W  = 1024;
    localparam int GRID_MAX_G  = 15;
    localparam int RING_DEPTH  = (2 * GRID_MAX_G + 1) * GRID_MAX_W;
    localparam int SETTLE_CYC  = 40;
    localparam int STALL_LIMIT = 20000;
    localparam int TARGET_WORDS = 400;
    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] value;
    } t_word;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_kind;
    logic signed [VAL_W-1:0] i_cell_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [VAL_W-1:0] o_out_value;
    logic                    o_last_cell;

    occupancy_grid_obstacle_dilation_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_cell_value(i_cell_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_value (o_out_value),
        .o_last_cell (o_last_cell)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // dilation model state
    logic [VAL_W-1:0] grid_ring [0:RING_DEPTH-1];
    int unsigned      cells_seen;
    int unsigned      cells_sent;
    int unsigned      reg_width;
    int unsigned      reg_height;
    int unsigned      reg_grow;
    int unsigned      reg_enable;

    logic [VAL_W-1:0] grown_q[$];
    logic             last_q[$];
    t_word            word_q[$];

    int  error_count;
    int  idle_pct;
    int  stall_pct;
    int  watchdog;
    int  words_queued;
    bit  in_taken;

    function automatic bit is_source(logic [VAL_W-1:0] v);
        return ($signed(v) > OCC_LIMIT) || ($signed(v) < 0);
    endfunction

    function automatic logic [VAL_W-1:0] dilated_cell(int unsigned p, int unsigned w,
                                                      int unsigned h, int unsigned g);
        int unsigned r;
        int unsigned c;
        int unsigned rlo;
        int unsigned rhi;
        int unsigned clo;
        int unsigned chi;
        r = p / w;
        c = p % w;
        if (reg_enable[0] && w >= 2 * g + 1 && h >= 2 * g + 1) begin
            rlo = (r > 2 * g) ? r - g : g;
            rhi = (r + g > h - 1 - g) ? h - 1 - g : r + g;
            clo = (c > 2 * g) ? c - g : g;
            chi = (c + g > w - 1 - g) ? w - 1 - g : c + g;
            for (int unsigned rr = rlo; rr <= rhi; rr++)
                for (int unsigned cc = clo; cc <= chi; cc++)
                    if (is_source(grid_ring[(rr * w + cc) % RING_DEPTH]))
                        return GROWN_VALUE;
        end
        return grid_ring[p % RING_DEPTH];
    endfunction

    function automatic void dilate_word(logic kind, logic [VAL_W-1:0] value);
        int unsigned w;
        int unsigned h;
        int unsigned g;
        int unsigned total;
        bit          emit;
        w = (reg_width < 1) ? 1 : (reg_width > GRID_MAX_W ? GRID_MAX_W : reg_width);
        h = (reg_height < 1) ? 1 : (reg_height > MAX_HEIGHT ? MAX_HEIGHT : reg_height);
        g = (reg_grow > GRID_MAX_G) ? GRID_MAX_G : reg_grow;
        total = w * h;
        emit = 1'b0;
        if (cells_seen < total) begin
            if (kind == KIND_CELL) begin
                grid_ring[cells_seen % RING_DEPTH] = value;
                cells_seen++;
                if (cells_seen - cells_sent > g * w + g)
                    emit = 1'b1;
            end
        end else if (cells_sent < total) begin
            emit = 1'b1;
        end
        if (emit) begin
            grown_q.push_back(dilated_cell(cells_sent, w, h, g));
            last_q.push_back(cells_sent == total - 1);
            cells_sent++;
            if (cells_sent >= total) begin
                cells_seen = 0;
                cells_sent = 0;
            end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
        if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid   <= 1'b1;
                i_kind       <= word_q[0].kind;
                i_cell_value <= word_q[0].value;
                word_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            watchdog++;
            if (i_cfg_we)
                watchdog = 0;
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                watchdog = 0;
                dilate_word(i_kind, i_cell_value);
            end
            if (o_out_valid && i_out_ready) begin
                watchdog = 0;
                if (grown_q.size() == 0) begin
                    report_mismatch("unexpected word value", o_out_value, 0);
                end else begin
                    if (o_out_value !== grown_q[0])
                        report_mismatch("out_value", o_out_value, $signed(grown_q[0]));
                    if (o_last_cell !== last_q[0])
                        report_mismatch("last_cell", o_last_cell, last_q[0]);
                    void'(grown_q.pop_front());
                    void'(last_q.pop_front());
                end
            end
            if (watchdog >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (word_q.size() > 0 || i_in_valid || grown_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_W-1:0];
        case (idx)
            CFG_MAP_WIDTH:   reg_width  = data & 32'h7ff;
            CFG_MAP_HEIGHT:  reg_height = data & 32'h7ff;
            CFG_GROW_STEPS:  reg_grow   = data & 32'hf;
            CFG_GROW_ENABLE: reg_enable = data & 32'h1;
            default: ;
        endcase
        cells_seen = 0;
        cells_sent = 0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup_map(int unsigned w, int unsigned h, int unsigned g, int unsigned en);
        wait_drained();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_GROW_STEPS, g);
        write_reg(CFG_GROW_ENABLE, en);
    endtask

    task automatic push_word(logic kind, logic [VAL_W-1:0] value);
        t_word wd;
        wd.kind  = kind;
        wd.value = value;
        word_q.push_back(wd);
        words_queued++;
    endtask

    function automatic logic [VAL_W-1:0] random_occupancy();
        case ($urandom_range(9))
            0:       return 8'hff;
            1:       return VAL_W'($urandom_range(255));
            2, 3:    return VAL_W'($urandom_range(100, 41));
            default: return VAL_W'($urandom_range(40));
        endcase
    endfunction

    // raster map plus tail words of random kind; random flush words are mixed in as noise
    task automatic stream_map(int unsigned cells, int unsigned tail);
        for (int unsigned i = 0; i < cells; i++) begin
            if ($urandom_range(19) == 0)
                push_word(KIND_FLUSH, VAL_W'($urandom_range(255)));
            push_word(KIND_CELL, random_occupancy());
        end
        for (int unsigned i = 0; i < tail; i++)
            push_word(1'($urandom_range(1)), VAL_W'($urandom_range(255)));
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned g;
        int unsigned phase;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_CELL;
        i_cell_value = '0;
        i_out_ready  = 1'b0;
        in_taken     = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        watchdog     = 0;
        error_count  = 0;
        words_queued = 0;
        cells_seen   = 0;
        cells_sent   = 0;
        reg_width    = 1024;
        reg_height   = 1024;
        reg_grow     = 0;
        reg_enable   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 3x3 map, radius 1: only the center may be a source
        setup_map(3, 3, 1, 1);
        push_word(KIND_CELL, 8'h00);
        push_word(KIND_CELL, 8'h7f);
        push_word(KIND_CELL, 8'd40);
        push_word(KIND_FLUSH, 8'hff);
        push_word(KIND_CELL, 8'h80);
        push_word(KIND_CELL, 8'd40);
        push_word(KIND_CELL, 8'h00);
        push_word(KIND_CELL, 8'h00);
        push_word(KIND_CELL, 8'h00);
        push_word(KIND_CELL, 8'hff);
        for (int i = 0; i < 4; i++)
            push_word(KIND_FLUSH, 8'h55);
        // same map with a source in the center
        for (int i = 0; i < 9; i++)
            push_word(KIND_CELL, (i == 4) ? 8'd41 : 8'd7);
        push_word(KIND_CELL, 8'haa);
        for (int i = 0; i < 3; i++)
            push_word(KIND_FLUSH, 8'h00);

        // register extremes, partial maps
        setup_map(2047, 1, 0, 1);
        stream_map(20, 0);
        setup_map(0, 2047, 15, 0);
        stream_map(50, 0);
        setup_map(15, 15, 7, 1);
        stream_map(130, 0);
        setup_map(1, 0, 0, 0);
        stream_map(4, 3);

        phase = 0;
        while (words_queued < TARGET_WORDS) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            phase++;
            w = $urandom_range(8, 1);
            h = $urandom_range(8, 1);
            g = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(2);
            setup_map(w, h, g, $urandom_range(3) != 0);
            if (g > GRID_MAX_G) g = GRID_MAX_G;
            if ($urandom_range(9) == 0)
                stream_map($urandom_range(w * h), $urandom_range(3));
            else
                stream_map(w * h, g * w + g + $urandom_range(2));
        end

        wait_drained();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
